// ===== hdl/ivim_pkg.sv =====
package ivim_pkg;

  localparam int EXP_FRAC_BITS_DEF = 16;

  // Rounded log2(e) in Q30.
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  localparam logic [16:0] FRAC_ONE = 17'd65536;
  localparam logic [16:0] FRAC_099 = 17'd64881;
  localparam logic [9:0]  HALF_THOUSAND = 10'd500;

  // floor(2^38 / 125): reciprocal for the divide by 125 after a shift by 3.
  localparam logic [31:0] DIV_M = 32'((64'd1 << 38) / 64'd125);

  // Latency of the exp lane, the mixing stages and the whole pipeline.
  localparam int EXP_LAT  = 22;
  localparam int MIX_LAT  = 3;
  localparam int PIPE_LAT = 1 + EXP_LAT + MIX_LAT;

  typedef struct packed {
    logic [23:0] d_lo;
    logic [23:0] d_hi;
    logic [16:0] frac;
    logic [30:0] s0;
    logic [15:0] b;
  } cond_t;

  typedef struct packed {
    logic [16:0] frac;
    logic [30:0] s0;
  } side_t;

  typedef logic [15:0][29:0] root_arr_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = v_in;
    res = 64'd0;
    bt  = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Entry i approximates 2^(-2^-(i+1)) in Q30.
  function automatic root_arr_t make_roots();
    root_arr_t   tbl;
    logic [63:0] c;
    c = isqrt64(64'd1 << 59);
    for (int i = 0; i < 16; i++) begin
      tbl[i] = c[29:0];
      c = isqrt64(c << 30);
    end
    return tbl;
  endfunction

  localparam root_arr_t ROOTS = make_roots();

endpackage

// ===== hdl/ivim_cond.sv =====
module ivim_cond import ivim_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [24:0] adc,
  input  logic signed [24:0] pseudo_adc,
  input  logic signed [18:0] perf_fraction,
  input  logic signed [31:0] base_signal,
  input  logic        [15:0] b_value,
  output cond_t              cond
);

  cond_t       cond_r;
  cond_t       cond_nxt;
  logic [23:0] dadc;
  logic [23:0] dpadc;

  always_comb begin
    dadc  = (adc[24] || adc == 25'sd0) ? 24'd1 : adc[23:0];
    dpadc = (pseudo_adc[24] || pseudo_adc == 25'sd0) ? 24'd1 : pseudo_adc[23:0];
    // The smaller coefficient always drives the diffusion term.
    if (dpadc < dadc) begin
      cond_nxt.d_lo = dpadc;
      cond_nxt.d_hi = dadc;
    end else begin
      cond_nxt.d_lo = dadc;
      cond_nxt.d_hi = dpadc;
    end
    if (perf_fraction[18] || perf_fraction == 19'sd0) begin
      cond_nxt.frac = 17'd1;
    end else if (perf_fraction[17:0] > 18'(FRAC_ONE)) begin
      cond_nxt.frac = FRAC_099;
    end else begin
      cond_nxt.frac = perf_fraction[16:0];
    end
    cond_nxt.s0 = (base_signal[31] || base_signal == 32'sd0) ? 31'd1 : base_signal[30:0];
    cond_nxt.b  = b_value;
  end

  always_ff @(posedge clk) begin
    if (en) cond_r <= cond_nxt;
  end

  assign cond = cond_r;

endmodule

// ===== hdl/ivim_exp.sv =====
module ivim_exp import ivim_pkg::*; #(
  parameter int EXP_FRAC_BITS = EXP_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [23:0]            d,
  input  logic [15:0]            b,
  output logic [EXP_FRAC_BITS:0] e
);

  logic [40:0] v_r;
  logic [50:0] ph_r, pl_r;
  logic [37:0] w_r, w2_r;
  logic [30:0] q0_r;
  logic [30:0] x_r;
  logic [30:0] acc_r [17];
  logic [15:0] rb_r  [17];
  logic [15:0] n_r   [17];
  logic [EXP_FRAC_BITS:0] e_r;

  logic [37:0] w;
  logic [69:0] qsum;
  logic [37:0] q125;
  logic [37:0] rem;
  logic [61:0] tp;
  logic [16:0] s;
  logic [4:0]  sh;
  logic [31:0] rsum;
  logic [31:0] shifted;

  always_comb begin
    w       = v_r[40:3];
    qsum    = {ph_r, 19'b0} + {19'b0, pl_r};
    q125    = {q0_r, 7'b0} - 38'({q0_r, 2'b0}) + 38'(q0_r);
    rem     = w2_r - q125;
    tp      = 62'(x_r) * 62'(LOG2E_Q30) + (62'd1 << 29);
    s       = 17'(30 - EXP_FRAC_BITS) + 17'(n_r[16]);
    sh      = s[4:0];
    rsum    = 32'(acc_r[16]) + (32'd1 << (sh - 5'd1));
    shifted = rsum >> sh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r   <= 41'(d) * 41'(b) + 41'(HALF_THOUSAND);
      ph_r  <= 51'(w[37:19]) * 51'(DIV_M);
      pl_r  <= 51'(w[18:0]) * 51'(DIV_M);
      w_r   <= w;
      q0_r  <= qsum[68:38];
      w2_r  <= w_r;
      // The estimate is low by at most one.
      x_r   <= (rem >= 38'd125) ? q0_r + 31'd1 : q0_r;
      acc_r[0] <= 31'd1 << 30;
      rb_r[0]  <= tp[45:30];
      n_r[0]   <= tp[61:46];
      e_r   <= (s >= 17'd32) ? '0 : shifted[EXP_FRAC_BITS:0];
    end
  end

  // One root multiply per stage, selected by one bit of the fraction.
  for (genvar k = 0; k < 16; k++) begin : g_root
    logic [60:0] prod;
    assign prod = 61'(acc_r[k]) * 61'(ROOTS[k]) + (61'd1 << 29);
    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k+1] <= rb_r[k][15-k] ? prod[60:30] : acc_r[k];
        rb_r[k+1]  <= rb_r[k];
        n_r[k+1]   <= n_r[k];
      end
    end
  end

  assign e = e_r;

endmodule

// ===== hdl/ivim_mix.sv =====
module ivim_mix import ivim_pkg::*; #(
  parameter int EXP_FRAC_BITS = EXP_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [EXP_FRAC_BITS:0] e_p,
  input  logic [EXP_FRAC_BITS:0] e_d,
  input  side_t                  side,
  output logic [30:0]            sig
);

  localparam int PW = 18 + EXP_FRAC_BITS;

  logic [PW-1:0] pp_r, pd_r;
  logic [30:0]   s0a_r, s0b_r;
  logic [16:0]   m_r;
  logic [30:0]   sig_r;
  logic [PW:0]   msum;
  logic [47:0]   sprod;

  always_comb begin
    msum  = (PW+1)'(pp_r) + (PW+1)'(pd_r) + ((PW+1)'(1) << (EXP_FRAC_BITS - 1));
    sprod = 48'(s0b_r) * 48'(m_r) + (48'd1 << 15);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r  <= PW'(side.frac) * PW'(e_p);
      pd_r  <= PW'(FRAC_ONE - side.frac) * PW'(e_d);
      s0a_r <= side.s0;
      m_r   <= msum[EXP_FRAC_BITS+16:EXP_FRAC_BITS];
      s0b_r <= s0a_r;
      sig_r <= sprod[46:16];
    end
  end

  assign sig = sig_r;

endmodule

// ===== hdl/ivim_biexponential_signal_core.sv =====
// IVIM bi-exponential signal core: each accepted word carries one parameter
// set and one b value and yields one predicted signal word, in order, at a
// sustained rate of one word per clock while out_stall is low. The pipeline
// depth is set by the exp lanes, which spend one stage on the coefficient
// product, three on the divide by 1000, one on the base-2 conversion, sixteen
// on the root multiplies (one per fraction bit) and one on the final scaling;
// one conditioning stage sits in front and three mixing stages follow. The
// whole pipeline advances together: while a finished word waits under
// out_stall, in_stall is raised and nothing moves, so no word is lost or
// repeated. Negative inputs are floored to one LSB, a fraction above one
// becomes 0.99, and the two coefficients are ordered so that the larger one
// feeds the perfusion term.
module ivim_biexponential_signal_core import ivim_pkg::*; #(
  parameter int EXP_FRAC_BITS = EXP_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [24:0] in_adc,
  input  logic signed [24:0] in_pseudo_adc,
  input  logic signed [18:0] in_perf_fraction,
  input  logic signed [31:0] in_base_signal,
  input  logic        [15:0] in_b_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [30:0] out_signal
);

  logic                   en;
  logic [PIPE_LAT-1:0]    vld_r;
  logic [PIPE_LAT-1:0]    vld_nxt;
  cond_t                  cond;
  side_t                  side_r [EXP_LAT];
  logic [EXP_FRAC_BITS:0] e_p, e_d;

  // The pipeline moves unless a finished word is being held back.
  assign en       = !(vld_r[PIPE_LAT-1] && out_stall);
  assign in_stall = !en;
  assign vld_nxt  = {vld_r[PIPE_LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  ivim_cond u_cond (
    .clk           (clk),
    .en            (en),
    .adc           (in_adc),
    .pseudo_adc    (in_pseudo_adc),
    .perf_fraction (in_perf_fraction),
    .base_signal   (in_base_signal),
    .b_value       (in_b_value),
    .cond          (cond)
  );

  ivim_exp #(.EXP_FRAC_BITS(EXP_FRAC_BITS)) u_exp_p (
    .clk (clk),
    .en  (en),
    .d   (cond.d_hi),
    .b   (cond.b),
    .e   (e_p)
  );

  ivim_exp #(.EXP_FRAC_BITS(EXP_FRAC_BITS)) u_exp_d (
    .clk (clk),
    .en  (en),
    .d   (cond.d_lo),
    .b   (cond.b),
    .e   (e_d)
  );

  // Fraction and base signal ride alongside the exp lanes.
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= '{frac: cond.frac, s0: cond.s0};
      for (int i = 1; i < EXP_LAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  ivim_mix #(.EXP_FRAC_BITS(EXP_FRAC_BITS)) u_mix (
    .clk  (clk),
    .en   (en),
    .e_p  (e_p),
    .e_d  (e_d),
    .side (side_r[EXP_LAT-1]),
    .sig  (out_signal)
  );

  assign out_valid = vld_r[PIPE_LAT-1];

  // The input is only held off while a finished word waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled without a waiting result");

  // A held pipeline keeps every valid bit in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid bits moved during a stall");

  // A conditioned fraction never exceeds one.
  a_frac: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> (cond.frac <= FRAC_ONE && cond.frac != 17'd0))
    else $error("conditioned fraction out of range");

  // An accepted word shows up in the next stage.
  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && en) |=> vld_r[0])
    else $error("accepted word lost at entry");

endmodule
